// File: hw/rtl/nfh_pkg.sv
package nfh_pkg;

    // Table geometry; BUCKETS is a power of two.
    localparam int BUCKETS     = 1024;
    localparam int TABLES      = 2;
    localparam int WEIGHT_BITS = 32;

    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int MEM_DEPTH   = TABLES * BUCKETS;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
    localparam int SUM_BITS    = 48;

    // Field widths fixed by the stream format
    localparam int WADDR_BITS     = 11;
    localparam int WVALUE_BITS    = 32;
    localparam int CHAR_BITS      = 8;
    localparam int IN_DATA_BITS   = 56;
    localparam int IN_USER_BITS   = 2;
    localparam int OUT_DATA_BITS  = 48;
    localparam int OUT_USER_BITS  = 2;

    // tdata / tuser bit positions
    localparam int WADDR_LSB  = 0;
    localparam int WVALUE_LSB = WADDR_LSB + WADDR_BITS;
    localparam int CHAR_LSB   = WVALUE_LSB + WVALUE_BITS;
    localparam int USR_ACTION = 0;
    localparam int USR_TABLE  = 1;
    localparam int USR_SHORT  = 0;
    localparam int USR_SAT    = 1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_FEED = 1'b1;

    // murmur3 x86_32 constants
    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_N   = 32'he6546b64;
    localparam logic [31:0] MM_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM_F2  = 32'hc2b2ae35;
    localparam logic [31:0] MM_LEN = 32'd4;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5a) begin
            return b | 8'h20;
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/nfh_ram.sv
module nfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ngram_murmur_feature_hash_sum.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: weight_address, weight_value, char_byte; tuser: action, table_select;
//                tlast: last_char
// m_axis    out  tdata: weight_sum; tuser: too_short, sum_saturated
//
// A load beat, or a byte that only fills the window, is taken in the idle state; once three
// bytes are held, a byte steps through two multiplies on one shared 32x32 multiplier, a mix
// step, two more multiplies, the bucket address, and the weight RAM read and accumulate.
// A final byte then passes a done state that hands the result to the output register.
// Reset clears the window, byte count, sum and clip flag; the weight RAM is not cleared.
// The result waits in the output register; a final byte stays in the done state, holding off
// the input, only while the previous result still sits there unaccepted.
module ngram_murmur_feature_hash_sum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [10:0] weight_address, [42:11] weight_value, [50:43] char_byte, [55:51] zero
    input  logic [nfh_pkg::IN_DATA_BITS-1:0]     i_s_axis_tdata,
    // [0] action, [1] table_select
    input  logic [nfh_pkg::IN_USER_BITS-1:0]     i_s_axis_tuser,
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [47:0] weight_sum
    output logic [nfh_pkg::OUT_DATA_BITS-1:0]    o_m_axis_tdata,
    // [0] too_short, [1] sum_saturated
    output logic [nfh_pkg::OUT_USER_BITS-1:0]    o_m_axis_tuser
);

    import nfh_pkg::*;

    localparam int LA_BITS = ((ADDR_BITS > WADDR_BITS) ? ADDR_BITS : WADDR_BITS) + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MIX, ST_MUL3, ST_MUL4, ST_ADDR, ST_ACC, ST_DONE
    } t_state;

    t_state                     r_state;
    logic [23:0]                r_win;
    logic [1:0]                 r_seen;
    logic signed [SUM_BITS-1:0] r_sum;
    logic                       r_clip;
    logic [31:0]                r_x;
    logic                       r_last;
    logic                       r_tsel;
    logic                       r_full;
    logic                       r_out_valid;
    logic [SUM_BITS-1:0]        r_out_sum;
    logic                       r_out_short;
    logic                       r_out_sat;

    logic                       in_acc;
    logic                       in_action;
    logic [WADDR_BITS-1:0]      in_waddr;
    logic [WVALUE_BITS-1:0]     in_wvalue;
    logic [7:0]                 in_byte;
    logic [LA_BITS-1:0]         ld_addr;
    logic                       ld_in_range;

    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [31:0]                prod;
    logic [31:0]                mix_h;
    logic [31:0]                mix_t;
    logic [31:0]                fin_h;
    logic [31:0]                fin_mag;
    logic [ADDR_BITS:0]         rd_addr;

    logic                       mem_we;
    logic [ADDR_BITS-1:0]       mem_addr;
    logic [WEIGHT_BITS-1:0]     mem_rdata;

    logic signed [SUM_BITS:0]   w_ext;
    logic signed [SUM_BITS:0]   s_ext;
    logic signed [SUM_BITS-1:0] n_sum;
    logic                       n_clip;
    logic                       out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_action       = i_s_axis_tuser[USR_ACTION];
    assign in_waddr        = i_s_axis_tdata[WADDR_LSB +: WADDR_BITS];
    assign in_wvalue       = i_s_axis_tdata[WVALUE_LSB +: WVALUE_BITS];
    assign in_byte         = to_lower(i_s_axis_tdata[CHAR_LSB +: CHAR_BITS]);

    assign ld_addr     = LA_BITS'(in_waddr);
    assign ld_in_range = (ld_addr < LA_BITS'(MEM_DEPTH));

    // shared multiplier; operand pre-mix by step
    always_comb begin
        unique case (r_state)
            ST_MUL1: begin
                mul_a = r_x;
                mul_b = MM_C1;
            end
            ST_MUL2: begin
                mul_a = rotl32(r_x, 15);
                mul_b = MM_C2;
            end
            ST_MUL3: begin
                mul_a = r_x;
                mul_b = MM_F1;
            end
            ST_MUL4: begin
                mul_a = r_x ^ (r_x >> 13);
                mul_b = MM_F2;
            end
            default: begin
                mul_a = r_x;
                mul_b = MM_C1;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // h = rotl(k,13)*5 + n, then length and first fmix shift
    always_comb begin
        mix_h = rotl32(r_x, 13);
        mix_t = (mix_h + (mix_h << 2) + MM_N) ^ MM_LEN;
    end

    // final xor-shift, magnitude, bucket
    always_comb begin
        fin_h   = r_x ^ (r_x >> 16);
        fin_mag = fin_h[31] ? (~fin_h + 32'd1) : fin_h;
        rd_addr = (ADDR_BITS + 1)'((TABLES > 1 && r_tsel) ? BUCKETS : 0)
                + (ADDR_BITS + 1)'(fin_mag[BUCKET_BITS-1:0]);
    end

    assign mem_we   = in_acc && (in_action == ACT_LOAD) && ld_in_range;
    assign mem_addr = (r_state == ST_ADDR) ? rd_addr[ADDR_BITS-1:0]
                                           : ld_addr[ADDR_BITS-1:0];

    nfh_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (in_wvalue[WEIGHT_BITS-1:0]),
        .o_rdata (mem_rdata)
    );

    // saturating accumulate
    always_comb begin
        w_ext  = (SUM_BITS + 1)'(signed'(mem_rdata));
        s_ext  = (SUM_BITS + 1)'(r_sum) + w_ext;
        n_clip = r_clip;
        if (s_ext[SUM_BITS] != s_ext[SUM_BITS-1]) begin
            n_sum  = s_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
            n_clip = 1'b1;
        end else begin
            n_sum = s_ext[SUM_BITS-1:0];
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= '0;
            r_seen      <= '0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes the register in the cycle the old one leaves
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && in_action == ACT_FEED) begin
                        r_win  <= {in_byte, r_win[23:8]};
                        r_last <= i_s_axis_tlast;
                        r_tsel <= i_s_axis_tuser[USR_TABLE];
                        if (r_seen == 2'd3) begin
                            r_x     <= {in_byte, r_win};
                            r_full  <= 1'b1;
                            r_state <= ST_MUL1;
                        end else begin
                            r_seen <= r_seen + 2'd1;
                            r_full <= 1'b0;
                            if (i_s_axis_tlast) begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_MUL1: begin
                    r_x     <= prod;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_x     <= prod;
                    r_state <= ST_MIX;
                end
                ST_MIX: begin
                    r_x     <= mix_t ^ (mix_t >> 16);
                    r_state <= ST_MUL3;
                end
                ST_MUL3: begin
                    r_x     <= prod;
                    r_state <= ST_MUL4;
                end
                ST_MUL4: begin
                    r_x     <= prod;
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_sum   <= n_sum;
                    r_clip  <= n_clip;
                    r_state <= r_last ? ST_DONE : ST_IDLE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_sum   <= r_full ? r_sum : '0;
                        r_out_short <= !r_full;
                        r_out_sat   <= r_full && r_clip;
                        r_win       <= '0;
                        r_seen      <= '0;
                        r_sum       <= '0;
                        r_clip      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid           = r_out_valid;
    assign o_m_axis_tdata            = r_out_sum;
    assign o_m_axis_tuser[USR_SHORT] = r_out_short;
    assign o_m_axis_tuser[USR_SAT]   = r_out_sat;

endmodule
